[rtl/deadline_ordered_timer_queue_macros.svh]
// ----------------------------------------------------------------------------
// Assertion macros for the timer queue
// Concurrent checks on clk, disabled while rst_n is low; empty for synthesis.
// ----------------------------------------------------------------------------
`ifndef DEADLINE_ORDERED_TIMER_QUEUE_MACROS_SVH
`define DEADLINE_ORDERED_TIMER_QUEUE_MACROS_SVH

`ifndef SYNTHESIS
// prop must hold at every clock edge outside reset
`define DOTQ_ASSERT(lbl, prop, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (prop)) else $error(msg);
// cond must never be true outside reset
`define DOTQ_NEVER(lbl, cond, msg) \
    `DOTQ_ASSERT(lbl, !(cond), msg)
`else
`define DOTQ_ASSERT(lbl, prop, msg)
`define DOTQ_NEVER(lbl, cond, msg)
`endif

`endif

[rtl/dotq_pkg.sv]
// ----------------------------------------------------------------------------
// dotq_pkg
// Shared types and constants of the deadline ordered timer queue.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

package dotq_pkg;

    localparam int MAX_HANDLES = 64;
    localparam int SLOTS       = MAX_HANDLES - 1;
    localparam int HW          = 6;   // handle width
    localparam int TW          = 48;  // time width
    localparam int IW          = 32;  // interval width
    localparam int CW          = 6;   // slot count width

    typedef enum logic [1:0] {
        CMD_SCHED  = 2'd0,
        CMD_CANCEL = 2'd1,
        CMD_TICK   = 2'd2,
        CMD_UNUSED = 2'd3
    } cmd_t;

    typedef enum logic [1:0] {
        STS_OK   = 2'd0,
        STS_FULL = 2'd1,
        STS_BAD  = 2'd2,
        STS_RSVD = 2'd3
    } sts_t;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_SCHED,
        ST_FIND,
        ST_REMOVE,
        ST_POP,
        ST_NOP
    } state_t;

    typedef enum logic [2:0] {
        OP_NONE,
        OP_INSERT,
        OP_MATCH,
        OP_REMOVE,
        OP_POP,
        OP_NOP
    } op_t;

    typedef struct packed {
        logic accept;   // latch input transaction
        logic is_tick;  // accepted transaction is a tick
        op_t  op;
    } ctl_cmd_t;

    typedef struct packed {
        logic out_free;  // output register can take a result
        logic head_exp;  // head entry has expired
        logic next_exp;  // second entry has expired too
    } dp_sts_t;

endpackage

[rtl/dotq_datapath.sv]
// ----------------------------------------------------------------------------
// dotq_datapath
// Sorted cell chain, handle map, time counter and output register.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

`include "deadline_ordered_timer_queue_macros.svh"

module dotq_datapath
    import dotq_pkg::*;
(
    input  logic           clk,
    input  logic           rst_n,
    input  ctl_cmd_t       cmd,
    output dp_sts_t        sts,
    input  logic [IW-1:0]  in_interval,
    input  logic [HW-1:0]  in_handle,
    input  logic           out_ready,
    output logic           out_valid,
    output logic [1:0]     out_status,
    output logic [HW-1:0]  out_handle,
    output logic           out_fired,
    output logic           out_last
);

    logic [TW-1:0]    dl_reg [SLOTS];
    logic [HW-1:0]    hd_reg [SLOTS];
    logic [TW-1:0]    dl_next [SLOTS];
    logic [HW-1:0]    hd_next [SLOTS];
    logic [SLOTS-1:0] vld_reg, vld_next;
    logic [CW-1:0]    count_reg, count_next;
    logic [MAX_HANDLES-1:0] use_reg, use_next;
    logic [TW-1:0]    now_reg, now_next;
    logic [TW-1:0]    newdl_reg, newdl_next;
    logic [HW-1:0]    ch_reg, ch_next;
    logic [SLOTS-1:0] match_reg, match_next;

    logic             ov_reg, ov_next;
    logic [1:0]       ost_reg, ost_next;
    logic [HW-1:0]    oh_reg, oh_next;
    logic             of_reg, of_next;
    logic             ol_reg, ol_next;

    logic [HW-1:0]    free_h;
    logic             full;
    logic [SLOTS-1:0] ge;
    logic [SLOTS-1:0] gone;
    logic             found;
    logic             exp_mask;

    // lowest free handle from 1 up; 0 when none
    always_comb
    begin
        free_h = '0;
        for (int i = MAX_HANDLES - 1; i >= 1; i--)
        begin
            if (!use_reg[i])
                free_h = HW'(i);
        end
    end

    assign full  = (count_reg == CW'(SLOTS)) || (free_h == '0);
    assign found = |match_reg;

    always_comb
    begin
        for (int i = 0; i < SLOTS; i++)
        begin
            ge[i]   = vld_reg[i] && (dl_reg[i] >= newdl_reg);
            gone[i] = |(match_reg & ~({SLOTS{1'b1}} << (i + 1)));
        end
    end

    assign sts.out_free = !ov_reg || out_ready;
    assign sts.head_exp = vld_reg[0] && (dl_reg[0] <= now_reg);
    assign sts.next_exp = vld_reg[1] && (dl_reg[1] <= now_reg);

    always_comb
    begin
        dl_next    = dl_reg;
        hd_next    = hd_reg;
        vld_next   = vld_reg;
        count_next = count_reg;
        use_next   = use_reg;
        now_next   = now_reg;
        newdl_next = newdl_reg;
        ch_next    = ch_reg;
        match_next = match_reg;
        ov_next    = ov_reg && !out_ready;
        ost_next   = ost_reg;
        oh_next    = oh_reg;
        of_next    = of_reg;
        ol_next    = ol_reg;
        exp_mask   = 1'b0;

        if (cmd.accept)
        begin
            newdl_next = now_reg + TW'(in_interval);
            ch_next    = in_handle;
            if (cmd.is_tick)
                now_next = now_reg + TW'(1);
        end

        case (cmd.op)
            OP_INSERT:
            begin
                ov_next  = 1'b1;
                of_next  = 1'b0;
                ol_next  = 1'b1;
                if (full)
                begin
                    ost_next = STS_FULL;
                    oh_next  = '0;
                end
                else
                begin
                    ost_next = STS_OK;
                    oh_next  = free_h;
                    use_next[free_h] = 1'b1;
                    count_next = count_reg + CW'(1);
                    for (int i = 0; i < SLOTS; i++)
                    begin
                        if (i > 0 && ge[i-1])
                        begin
                            dl_next[i]  = dl_reg[i-1];
                            hd_next[i]  = hd_reg[i-1];
                            vld_next[i] = 1'b1;
                        end
                        else if ((i == 0 || vld_reg[i-1]) && (ge[i] || !vld_reg[i]))
                        begin
                            dl_next[i]  = newdl_reg;
                            hd_next[i]  = free_h;
                            vld_next[i] = 1'b1;
                        end
                    end
                end
            end
            OP_MATCH:
            begin
                for (int i = 0; i < SLOTS; i++)
                    match_next[i] = vld_reg[i] && (hd_reg[i] == ch_reg) && (ch_reg != '0);
            end
            OP_REMOVE:
            begin
                ov_next  = 1'b1;
                oh_next  = '0;
                of_next  = 1'b0;
                ol_next  = 1'b1;
                ost_next = found ? STS_OK : STS_BAD;
                if (found)
                begin
                    use_next[ch_reg] = 1'b0;
                    count_next = count_reg - CW'(1);
                    for (int i = 0; i < SLOTS; i++)
                    begin
                        if (gone[i])
                        begin
                            if (i < SLOTS - 1)
                            begin
                                dl_next[i]  = dl_reg[i+1];
                                hd_next[i]  = hd_reg[i+1];
                                vld_next[i] = vld_reg[i+1];
                            end
                            else
                                vld_next[i] = 1'b0;
                        end
                    end
                end
            end
            OP_POP:
            begin
                ov_next  = 1'b1;
                ost_next = STS_OK;
                if (sts.head_exp)
                begin
                    oh_next = hd_reg[0];
                    of_next = 1'b1;
                    ol_next = !sts.next_exp;
                    use_next[hd_reg[0]] = 1'b0;
                    count_next = count_reg - CW'(1);
                    exp_mask = 1'b1;
                    for (int i = 0; i < SLOTS - 1; i++)
                    begin
                        dl_next[i]  = dl_reg[i+1];
                        hd_next[i]  = hd_reg[i+1];
                        vld_next[i] = vld_reg[i+1];
                    end
                    vld_next[SLOTS-1] = 1'b0;
                end
                else
                begin
                    oh_next = '0;
                    of_next = 1'b0;
                    ol_next = 1'b1;
                end
            end
            OP_NOP:
            begin
                ov_next  = 1'b1;
                ost_next = STS_OK;
                oh_next  = '0;
                of_next  = 1'b0;
                ol_next  = 1'b1;
            end
            default:
            begin
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            vld_reg   <= '0;
            count_reg <= '0;
            use_reg   <= '0;
            now_reg   <= '0;
            ov_reg    <= 1'b0;
        end
        else
        begin
            vld_reg   <= vld_next;
            count_reg <= count_next;
            use_reg   <= use_next;
            now_reg   <= now_next;
            ov_reg    <= ov_next;
        end
    end

    always_ff @(posedge clk)
    begin
        dl_reg    <= dl_next;
        hd_reg    <= hd_next;
        newdl_reg <= newdl_next;
        ch_reg    <= ch_next;
        match_reg <= match_next;
        ost_reg   <= ost_next;
        oh_reg    <= oh_next;
        of_reg    <= of_next;
        ol_reg    <= ol_next;
    end

    assign out_valid  = ov_reg;
    assign out_status = ost_reg;
    assign out_handle = oh_reg;
    assign out_fired  = of_reg;
    assign out_last   = ol_reg;

    `DOTQ_ASSERT(a_count_tracks_use, $countones(use_reg) == 32'(count_reg), "handle map out of step with slot count")
    `DOTQ_NEVER(a_handle_zero_used, use_reg[0], "handle zero allocated")
    `DOTQ_ASSERT(a_head_sorted, !vld_reg[1] || (dl_reg[0] <= dl_reg[1]), "head entries out of order")
    `DOTQ_ASSERT(a_pop_shifts, (cmd.op == OP_POP && exp_mask) |=> (count_reg == $past(count_reg) - CW'(1)), "pop did not shrink queue")

endmodule

[rtl/dotq_ctrl.sv]
// ----------------------------------------------------------------------------
// dotq_ctrl
// Command sequencer: accepts a transaction and steps the datapath.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module dotq_ctrl
    import dotq_pkg::*;
(
    input  logic      clk,
    input  logic      rst_n,
    input  logic      in_valid,
    output logic      in_ready,
    input  logic [1:0] in_cmd,
    input  dp_sts_t   sts,
    output ctl_cmd_t  cmd
);

    state_t state_reg, state_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            state_reg <= ST_IDLE;
        else
            state_reg <= state_next;
    end

    always_comb
    begin
        state_next  = state_reg;
        in_ready    = 1'b0;
        cmd.accept  = 1'b0;
        cmd.is_tick = 1'b0;
        cmd.op      = OP_NONE;
        case (state_reg)
            ST_IDLE:
            begin
                in_ready = 1'b1;
                if (in_valid)
                begin
                    cmd.accept  = 1'b1;
                    cmd.is_tick = (in_cmd == CMD_TICK);
                    case (in_cmd)
                        CMD_SCHED:  state_next = ST_SCHED;
                        CMD_CANCEL: state_next = ST_FIND;
                        CMD_TICK:   state_next = ST_POP;
                        default:    state_next = ST_NOP;
                    endcase
                end
            end
            ST_SCHED:
            begin
                if (sts.out_free)
                begin
                    cmd.op     = OP_INSERT;
                    state_next = ST_IDLE;
                end
            end
            ST_FIND:
            begin
                cmd.op     = OP_MATCH;
                state_next = ST_REMOVE;
            end
            ST_REMOVE:
            begin
                if (sts.out_free)
                begin
                    cmd.op     = OP_REMOVE;
                    state_next = ST_IDLE;
                end
            end
            ST_POP:
            begin
                if (sts.out_free)
                begin
                    cmd.op = OP_POP;
                    if (!(sts.head_exp && sts.next_exp))
                        state_next = ST_IDLE;
                end
            end
            ST_NOP:
            begin
                if (sts.out_free)
                begin
                    cmd.op     = OP_NOP;
                    state_next = ST_IDLE;
                end
            end
            default:
                state_next = ST_IDLE;
        endcase
    end

endmodule

[rtl/deadline_ordered_timer_queue.sv]
// ----------------------------------------------------------------------------
// deadline_ordered_timer_queue
// Timer queue sorted by absolute deadline with a lowest-free handle allocator.
// ----------------------------------------------------------------------------
// One transaction is handled at a time. A schedule is accepted and then
// inserted, a cancel runs a match search and then a removal, and a tick pops
// each expiring timer in turn (at least one result is always produced);
// unused commands give one empty result. The single sorted cell chain shifts
// by one position for each insert, removal or pop. Results sit in an output
// register, so the next transaction is accepted while the final result of
// the previous one still waits on m_tready; back-pressure stalls a multi-result
// tick between pops. Time is a 48-bit millisecond count that wraps, deadlines
// compare as plain unsigned values.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module deadline_ordered_timer_queue
    import dotq_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [39:0] s_tdata,   // [31:0] interval_ms, [37:32] cancel_handle, pad
    input  logic [1:0]  s_tuser,   // [1:0] cmd
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [7:0]  m_tdata,   // [5:0] handle_out, pad
    output logic [2:0]  m_tuser,   // [1:0] status, [2] fired
    output logic        m_tlast    // last result of the transaction
);

    ctl_cmd_t       cmd;
    dp_sts_t        sts;
    logic [HW-1:0]  handle_out;

    // sequencer: owns the input handshake
    dotq_ctrl u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (s_tvalid),
        .in_ready (s_tready),
        .in_cmd   (s_tuser),
        .sts      (sts),
        .cmd      (cmd)
    );

    // cell chain, handle map, clock and result register
    dotq_datapath u_dp (
        .clk         (clk),
        .rst_n       (rst_n),
        .cmd         (cmd),
        .sts         (sts),
        .in_interval (s_tdata[IW-1:0]),
        .in_handle   (s_tdata[IW+HW-1:IW]),
        .out_ready   (m_tready),
        .out_valid   (m_tvalid),
        .out_status  (m_tuser[1:0]),
        .out_handle  (handle_out),
        .out_fired   (m_tuser[2]),
        .out_last    (m_tlast)
    );

    assign m_tdata = {2'b00, handle_out};

endmodule
